// ----- design/ready_queue_cpu_scheduler_top_macros.svh -----
// assertion macros for the ready queue scheduler
`ifndef READY_QUEUE_CPU_SCHEDULER_TOP_MACROS_SVH
`define READY_QUEUE_CPU_SCHEDULER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RQS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define RQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RQS_ASSERT(lbl, prop, msg)
`define RQS_ASSERT_IMPL(lbl, ante, cons, msg)
`define RQS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/rqs_pkg.sv -----
// shared types and codes of the ready queue scheduler
package rqs_pkg;

  // event codes
  localparam logic [2:0] EV_WAKE    = 3'd0;
  localparam logic [2:0] EV_PREEMPT = 3'd1;
  localparam logic [2:0] EV_IDLE    = 3'd4;

  // result kinds
  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_PREEMPT  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CPUS      = 2'd2;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } entry_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] id;
    logic [7:0] prio;
  } slot_t;

  typedef enum logic [1:0] {
    Q_HOLD,
    Q_NEXT,
    Q_HEAD,
    Q_LOAD
  } qcell_op_e;

  typedef enum logic [1:0] {
    R_HOLD,
    R_NEXT,
    R_LOAD
  } rcell_op_e;

  typedef struct packed {
    qcell_op_e op;
    entry_t    load;
  } qcell_ctrl_t;

  typedef struct packed {
    rcell_op_e op;
    slot_t     load;
  } rcell_ctrl_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  target_cpu;
    logic        has_process;
    logic [7:0]  chosen_id;
    logic [15:0] slice;
    logic        overflow;
  } result_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_RING  = 7'b0000010,
    ST_ENQ   = 7'b0000100,
    ST_PICK  = 7'b0001000,
    ST_QSCAN = 7'b0010000,
    ST_POP   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

endpackage

// ----- design/rqs_ifs.sv -----
// handshake channel interfaces of the ready queue scheduler
interface rqs_ev_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [3:0] cpu;
  logic [7:0] process_id;
  logic [7:0] priority_req;
  modport source (output valid, mode, cpu, process_id, priority_req, input ready);
  modport sink (input valid, mode, cpu, process_id, priority_req, output ready);
endinterface

interface rqs_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  target_cpu;
  logic        has_process;
  logic [7:0]  chosen_id;
  logic [15:0] slice;
  logic        overflow;
  modport source (output valid, kind, target_cpu, has_process, chosen_id, slice, overflow,
                  input ready);
  modport sink (input valid, kind, target_cpu, has_process, chosen_id, slice, overflow,
                output ready);
endinterface

interface rqs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rqs_pkg::CFG_IDX_W-1:0]  index;
  logic [rqs_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/rqs_qcell.sv -----
// one ready queue cell: holds an entry, takes its neighbor, the head or a new entry
module rqs_qcell (
  input  logic                 clk_i,
  input  rqs_pkg::qcell_ctrl_t ctrl_i,
  input  rqs_pkg::entry_t      next_i,
  input  rqs_pkg::entry_t      head_i,
  output rqs_pkg::entry_t      q_o
);

  rqs_pkg::entry_t entry_q, entry_d;

  always_comb begin
    case (ctrl_i.op)
      rqs_pkg::Q_NEXT: entry_d = next_i;
      rqs_pkg::Q_HEAD: entry_d = head_i;
      rqs_pkg::Q_LOAD: entry_d = ctrl_i.load;
      default:         entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o = entry_q;

endmodule

// ----- design/rqs_rcell.sv -----
// one running table cell: what a cpu runs, shifted around the ring or loaded
module rqs_rcell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rqs_pkg::rcell_ctrl_t ctrl_i,
  input  rqs_pkg::slot_t       next_i,
  output rqs_pkg::slot_t       q_o
);

  logic       valid_q, valid_d;
  logic [7:0] id_q, id_d;
  logic [7:0] prio_q, prio_d;

  always_comb begin
    case (ctrl_i.op)
      rqs_pkg::R_NEXT: begin
        valid_d = next_i.valid;
        id_d    = next_i.id;
        prio_d  = next_i.prio;
      end
      rqs_pkg::R_LOAD: begin
        valid_d = ctrl_i.load.valid;
        id_d    = ctrl_i.load.id;
        prio_d  = ctrl_i.load.prio;
      end
      default: begin
        valid_d = valid_q;
        id_d    = id_q;
        prio_d  = prio_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign q_o = '{valid: valid_q, id: id_q, prio: prio_q};

endmodule

// ----- design/ready_queue_cpu_scheduler_top.sv -----
// multi-cpu ready queue scheduler: queue and running table as rows of cells
//
//  port   | dir | word                                          | taken when
//  cfg_i  | in  | index, data                                   | valid && ready
//  ev_i   | in  | mode, cpu, process_id, priority_req            | valid && ready
//  res_o  | out | kind, target_cpu, has_process, chosen_id,      | valid && ready
//         |     | slice, overflow                                |
//
// one event at a time; a wake-up in priority mode and a preempt turn the running ring once,
// a priority pick turns the queue once around its filled part
// a fifo wake-up only enqueues; yield/terminate/idle pick from the queue, idle on an empty
// queue gives no word; a preempt first puts the process that the cpu was running back in
// the queue
// reset empties the queue and marks every cpu idle; configuration resets too
// a waiting result sits in the output register, a new event is taken meanwhile
`include "ready_queue_cpu_scheduler_top_macros.svh"

module ready_queue_cpu_scheduler_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_CPUS    = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  rqs_cfg_if.sink   cfg_i,
  rqs_ev_if.sink    ev_i,
  rqs_res_if.source res_o
);

  localparam int QIW    = $clog2(QUEUE_DEPTH);
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int CPU_IW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int CMPW   = ((CPU_IW > 5) ? CPU_IW : 5) + 1;

  // configuration
  logic        prio_mode_q;
  logic [15:0] slice_q;
  logic [4:0]  cpus_q;

  // control
  rqs_pkg::state_e state_q, state_d;
  logic [QCW-1:0]    count_q, count_d;
  logic [CPU_IW-1:0] ring_q, ring_d;
  logic [QIW-1:0]    qstep_q, qstep_d;
  logic              out_valid_q, out_valid_d;

  // per-event working registers
  logic [2:0]        mode_q, mode_d;
  logic [3:0]        cpu_q, cpu_d;
  logic [7:0]        pid_q, pid_d;
  logic [7:0]        prio_q, prio_d;
  logic              ovf_q, ovf_d;
  logic [7:0]        lowest_q, lowest_d;
  logic              found_q, found_d;
  logic [CPU_IW-1:0] low_cpu_q, low_cpu_d;
  rqs_pkg::slot_t    cap_q, cap_d;
  logic [7:0]        best_id_q, best_id_d;
  logic [7:0]        best_prio_q, best_prio_d;
  logic [QIW-1:0]    pick_q, pick_d;
  rqs_pkg::result_t  res_q, res_d;
  rqs_pkg::result_t  out_q, out_d;

  // cells
  rqs_pkg::entry_t      qcell_q [QUEUE_DEPTH];
  rqs_pkg::entry_t      qnext   [QUEUE_DEPTH];
  rqs_pkg::qcell_ctrl_t qctrl   [QUEUE_DEPTH];
  rqs_pkg::slot_t       rslot   [MAX_CPUS];
  rqs_pkg::rcell_ctrl_t rctrl   [MAX_CPUS];

  rqs_pkg::entry_t enq_entry;
  logic            q_rotate;
  logic            q_full;

  // configuration port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_mode_q <= 1'b0;
      slice_q     <= '0;
      cpus_q      <= 5'd1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rqs_pkg::CFG_PRIO_MODE: prio_mode_q <= cfg_i.data[0];
        rqs_pkg::CFG_SLICE:     slice_q     <= cfg_i.data[15:0];
        rqs_pkg::CFG_CPUS:      cpus_q      <= cfg_i.data[4:0];
        default: ;
      endcase
    end
  end

  assign q_full    = (count_q == QCW'(QUEUE_DEPTH));
  assign enq_entry = (mode_q == rqs_pkg::EV_WAKE) ? '{id: pid_q, prio: prio_q}
                                                  : '{id: cap_q.id, prio: cap_q.prio};
  // the queue turns once around its filled part during a priority search
  assign q_rotate  = ((state_q == rqs_pkg::ST_PICK) && prio_mode_q && (count_q > QCW'(1)))
                     || (state_q == rqs_pkg::ST_QSCAN);

  // queue cell controls
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      qctrl[k].op   = rqs_pkg::Q_HOLD;
      qctrl[k].load = enq_entry;
      if ((state_q == rqs_pkg::ST_ENQ) && !q_full && (QCW'(k) == count_q)) begin
        qctrl[k].op = rqs_pkg::Q_LOAD;
      end else if (q_rotate) begin
        if (QCW'(k + 1) < count_q) begin
          qctrl[k].op = rqs_pkg::Q_NEXT;
        end else if (QCW'(k + 1) == count_q) begin
          qctrl[k].op = rqs_pkg::Q_HEAD;
        end
      end else if ((state_q == rqs_pkg::ST_POP) && (QIW'(k) >= pick_q)
                   && (QCW'(k + 1) < count_q)) begin
        qctrl[k].op = rqs_pkg::Q_NEXT;
      end
    end
  end

  // running cell controls
  always_comb begin
    for (int k = 0; k < MAX_CPUS; k++) begin
      rctrl[k].op   = rqs_pkg::R_HOLD;
      rctrl[k].load = '{valid: 1'b1, id: best_id_q, prio: best_prio_q};
      if (state_q == rqs_pkg::ST_RING) begin
        rctrl[k].op = rqs_pkg::R_NEXT;
      end else if (CMPW'(k) == CMPW'(cpu_q)) begin
        if ((state_q == rqs_pkg::ST_PICK) && (count_q == '0)) begin
          rctrl[k].op         = rqs_pkg::R_LOAD;
          rctrl[k].load.valid = 1'b0;
        end else if (state_q == rqs_pkg::ST_POP) begin
          rctrl[k].op = rqs_pkg::R_LOAD;
        end
      end
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_qcell
    if (g < QUEUE_DEPTH - 1) begin : g_mid
      assign qnext[g] = qcell_q[g+1];
    end else begin : g_last
      assign qnext[g] = qcell_q[g];
    end
    rqs_qcell u_qcell (
      .clk_i  (clk_i),
      .ctrl_i (qctrl[g]),
      .next_i (qnext[g]),
      .head_i (qcell_q[0]),
      .q_o    (qcell_q[g])
    );
  end

  for (genvar g = 0; g < MAX_CPUS; g++) begin : g_rcell
    rqs_rcell u_rcell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (rctrl[g]),
      .next_i (rslot[(g + 1) % MAX_CPUS]),
      .q_o    (rslot[g])
    );
  end

  assign ev_i.ready = (state_q == rqs_pkg::ST_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ring_d      = ring_q;
    qstep_d     = qstep_q;
    out_valid_d = out_valid_q;
    mode_d      = mode_q;
    cpu_d       = cpu_q;
    pid_d       = pid_q;
    prio_d      = prio_q;
    ovf_d       = ovf_q;
    lowest_d    = lowest_q;
    found_d     = found_q;
    low_cpu_d   = low_cpu_q;
    cap_d       = cap_q;
    best_id_d   = best_id_q;
    best_prio_d = best_prio_q;
    pick_d      = pick_q;
    res_d       = res_q;
    out_d       = out_q;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rqs_pkg::ST_IDLE: begin
        if (ev_i.valid) begin
          mode_d    = ev_i.mode;
          cpu_d     = ev_i.cpu;
          pid_d     = ev_i.process_id;
          prio_d    = ev_i.priority_req;
          ovf_d     = 1'b0;
          lowest_d  = ev_i.priority_req;
          found_d   = 1'b0;
          low_cpu_d = '0;
          cap_d     = '0;
          ring_d    = '0;
          if (ev_i.mode == rqs_pkg::EV_WAKE) begin
            state_d = rqs_pkg::ST_ENQ;
          end else if ((ev_i.mode > rqs_pkg::EV_IDLE)
                       || (CMPW'(ev_i.cpu) >= CMPW'(MAX_CPUS))) begin
            state_d = rqs_pkg::ST_IDLE;
          end else if (ev_i.mode == rqs_pkg::EV_PREEMPT) begin
            state_d = rqs_pkg::ST_RING;
          end else if ((ev_i.mode == rqs_pkg::EV_IDLE) && (count_q == '0)) begin
            state_d = rqs_pkg::ST_IDLE;
          end else begin
            state_d = rqs_pkg::ST_PICK;
          end
        end
      end
      rqs_pkg::ST_ENQ: begin
        if (q_full) begin
          ovf_d = 1'b1;
        end else begin
          count_d = count_q + QCW'(1);
        end
        if (mode_q == rqs_pkg::EV_WAKE) begin
          state_d = prio_mode_q ? rqs_pkg::ST_RING : rqs_pkg::ST_IDLE;
        end else begin
          state_d = rqs_pkg::ST_PICK;
        end
      end
      rqs_pkg::ST_RING: begin
        // cell 0 holds the slot of cpu ring_q during this pass
        ring_d = ring_q + CPU_IW'(1);
        if (mode_q == rqs_pkg::EV_WAKE) begin
          if ((CMPW'(ring_q) < CMPW'(cpus_q)) && rslot[0].valid
              && (rslot[0].prio < lowest_q)) begin
            lowest_d  = rslot[0].prio;
            found_d   = 1'b1;
            low_cpu_d = ring_q;
          end
        end else if (CMPW'(ring_q) == CMPW'(cpu_q)) begin
          cap_d = rslot[0];
        end
        if (ring_q == CPU_IW'(MAX_CPUS - 1)) begin
          ring_d = '0;
          if (mode_q == rqs_pkg::EV_WAKE) begin
            if (found_d) begin
              res_d.kind        = rqs_pkg::KIND_PREEMPT;
              res_d.target_cpu  = 4'(low_cpu_d);
              res_d.has_process = 1'b0;
              res_d.chosen_id   = '0;
              res_d.slice       = '0;
              res_d.overflow    = ovf_q;
              state_d           = rqs_pkg::ST_EMIT;
            end else begin
              state_d = rqs_pkg::ST_IDLE;
            end
          end else begin
            state_d = cap_d.valid ? rqs_pkg::ST_ENQ : rqs_pkg::ST_PICK;
          end
        end
      end
      rqs_pkg::ST_PICK: begin
        if (count_q == '0) begin
          res_d.kind        = rqs_pkg::KIND_DISPATCH;
          res_d.target_cpu  = cpu_q;
          res_d.has_process = 1'b0;
          res_d.chosen_id   = '0;
          res_d.slice       = slice_q;
          res_d.overflow    = ovf_q;
          state_d           = rqs_pkg::ST_EMIT;
        end else begin
          best_id_d   = qcell_q[0].id;
          best_prio_d = qcell_q[0].prio;
          pick_d      = '0;
          qstep_d     = QIW'(1);
          state_d     = q_rotate ? rqs_pkg::ST_QSCAN : rqs_pkg::ST_POP;
        end
      end
      rqs_pkg::ST_QSCAN: begin
        // strict compare keeps the earliest entry on ties
        if (qcell_q[0].prio > best_prio_q) begin
          best_id_d   = qcell_q[0].id;
          best_prio_d = qcell_q[0].prio;
          pick_d      = qstep_q;
        end
        qstep_d = qstep_q + QIW'(1);
        if ((QCW'(qstep_q) + QCW'(1)) == count_q) begin
          state_d = rqs_pkg::ST_POP;
        end
      end
      rqs_pkg::ST_POP: begin
        count_d           = count_q - QCW'(1);
        res_d.kind        = rqs_pkg::KIND_DISPATCH;
        res_d.target_cpu  = cpu_q;
        res_d.has_process = 1'b1;
        res_d.chosen_id   = best_id_q;
        res_d.slice       = slice_q;
        res_d.overflow    = ovf_q;
        state_d           = rqs_pkg::ST_EMIT;
      end
      rqs_pkg::ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = rqs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rqs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rqs_pkg::ST_IDLE;
      count_q     <= '0;
      ring_q      <= '0;
      qstep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ring_q      <= ring_d;
      qstep_q     <= qstep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    cpu_q       <= cpu_d;
    pid_q       <= pid_d;
    prio_q      <= prio_d;
    ovf_q       <= ovf_d;
    lowest_q    <= lowest_d;
    found_q     <= found_d;
    low_cpu_q   <= low_cpu_d;
    cap_q       <= cap_d;
    best_id_q   <= best_id_d;
    best_prio_q <= best_prio_d;
    pick_q      <= pick_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_q.kind;
  assign res_o.target_cpu  = out_q.target_cpu;
  assign res_o.has_process = out_q.has_process;
  assign res_o.chosen_id   = out_q.chosen_id;
  assign res_o.slice       = out_q.slice;
  assign res_o.overflow    = out_q.overflow;

  `RQS_ASSERT(a_count_bound, count_q <= QCW'(QUEUE_DEPTH), "queue count above depth")
  `RQS_ASSERT(a_count_step, (count_q == $past(count_q)) || (count_q == $past(count_q) + QCW'(1)) || (count_q == $past(count_q) - QCW'(1)), "queue count jumped")
  `RQS_ASSERT_IMPL(a_pop_nonempty, state_q == rqs_pkg::ST_POP, count_q != '0, "pop from empty queue")
  `RQS_ASSERT_IMPL(a_ring_home, (state_q == rqs_pkg::ST_RING) && (state_d != rqs_pkg::ST_RING), ring_q == CPU_IW'(MAX_CPUS - 1), "ring left before a full turn")
  `RQS_ASSERT_NEXT(a_emit_waits, (state_q == rqs_pkg::ST_EMIT) && out_valid_q && !res_o.ready, state_q == rqs_pkg::ST_EMIT, "result overwrote a waiting word")

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench of the ready queue cpu scheduler
`timescale 1ns / 1ps

module testbench;

  localparam int Q_DEPTH      = 16;
  localparam int N_CPUS       = 16;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 155;
  localparam int PLAN_LEN     = 17;

  localparam logic [2:0] EV_YIELD        = 3'd2;
  localparam logic [2:0] EV_TERM         = 3'd3;
  localparam logic [2:0] EV_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] EV_LAST_UNUSED  = 3'd7;
  localparam logic [15:0] SLICE_MAX      = 16'hFFFF;

  typedef enum logic [1:0] {ROW_EVENT, ROW_CFG} row_e;
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_RES} chk_e;

  typedef struct packed {
    row_e                          row;
    chk_e                          chk;
    logic [2:0]                    mode;
    logic [3:0]                    cpu;
    logic [7:0]                    pid;
    logic [7:0]                    prio;
    logic [4:0]                    reps;
    logic [rqs_pkg::CFG_IDX_W-1:0] idx;
    logic [15:0]                   data;
    rqs_pkg::result_t              res;
  } step_t;

  logic clk;
  logic rst_n;

  rqs_cfg_if cfg_if ();
  rqs_ev_if  ev_if ();
  rqs_res_if res_if ();

  ready_queue_cpu_scheduler_top u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .ev_i  (ev_if),
    .res_o (res_if)
  );

  // shadow of the scheduler state
  rqs_pkg::entry_t ready_q[$];
  rqs_pkg::slot_t  cpu_tab[N_CPUS];
  logic            prio_on;
  logic [15:0]     slice_cfg;
  int              cpus_cfg;

  rqs_pkg::result_t due_results[$];
  chk_e             row_check;
  rqs_pkg::result_t row_res;

  int err_cnt;
  int cycle_cnt;
  int n_events;
  int n_ignored;
  int n_results;
  int n_kicks;
  int n_idle_disp;
  int n_overflow;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                n_results, name, got, want));
  endtask

  // applies one event to the shadow state; returns 1 when a word is due
  function automatic bit schedule_event(input logic [2:0] m, input logic [3:0] c,
                                        input logic [7:0] p, input logic [7:0] pr,
                                        output rqs_pkg::result_t r);
    int          n;
    int          pick;
    int          low_cpu;
    logic [7:0]  lowest;
    bit          dropped;
    r = '0;
    dropped = 1'b0;
    if (m == rqs_pkg::EV_WAKE) begin
      dropped = (ready_q.size() >= Q_DEPTH);
      if (!dropped) ready_q.push_back('{p, pr});
      if (!prio_on) return 1'b0;
      n = (cpus_cfg < N_CPUS) ? cpus_cfg : N_CPUS;
      lowest = pr;
      low_cpu = -1;
      for (int i = 0; i < n; i++) begin
        if (cpu_tab[i].valid && cpu_tab[i].prio < lowest) begin
          lowest = cpu_tab[i].prio;
          low_cpu = i;
        end
      end
      if (low_cpu < 0) return 1'b0;
      r.kind = rqs_pkg::KIND_PREEMPT;
      r.target_cpu = low_cpu[3:0];
      r.overflow = dropped;
      return 1'b1;
    end
    if (m > rqs_pkg::EV_IDLE) return 1'b0;
    if (m == rqs_pkg::EV_PREEMPT && cpu_tab[c].valid) begin
      dropped = (ready_q.size() >= Q_DEPTH);
      if (!dropped) ready_q.push_back('{cpu_tab[c].id, cpu_tab[c].prio});
    end
    if (m == rqs_pkg::EV_IDLE && ready_q.size() == 0) return 1'b0;
    r.kind = rqs_pkg::KIND_DISPATCH;
    r.target_cpu = c;
    r.slice = slice_cfg;
    r.overflow = dropped;
    if (ready_q.size() == 0) begin
      cpu_tab[c].valid = 1'b0;
      return 1'b1;
    end
    pick = 0;
    if (prio_on) begin
      for (int i = 1; i < ready_q.size(); i++)
        if (ready_q[i].prio > ready_q[pick].prio) pick = i;
    end
    cpu_tab[c] = '{1'b1, ready_q[pick].id, ready_q[pick].prio};
    ready_q.delete(pick);
    r.has_process = 1'b1;
    r.chosen_id = cpu_tab[c].id;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch_channels
    rqs_pkg::result_t got;
    rqs_pkg::result_t want;
    rqs_pkg::result_t guess;
    bit               fired;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.kind, res_if.target_cpu, res_if.has_process, res_if.chosen_id,
                res_if.slice, res_if.overflow};
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word for cpu %0d", got.target_cpu));
        end else begin
          want = due_results.pop_front();
          check_field("kind", got.kind, want.kind);
          check_field("target_cpu", got.target_cpu, want.target_cpu);
          check_field("has_process", got.has_process, want.has_process);
          check_field("chosen_id", got.chosen_id, want.chosen_id);
          check_field("slice", got.slice, want.slice);
          check_field("overflow", got.overflow, want.overflow);
        end
        n_results++;
        if (got.kind == rqs_pkg::KIND_PREEMPT) n_kicks++;
        else if (!got.has_process) n_idle_disp++;
        if (got.overflow) n_overflow++;
      end
      if (ev_if.valid && ev_if.ready) begin
        fired = schedule_event(ev_if.mode, ev_if.cpu, ev_if.process_id, ev_if.priority_req,
                               guess);
        case (row_check)
          CHK_RES:  due_results.push_back(row_res);
          CHK_NONE: ;
          default:  if (fired) due_results.push_back(guess);
        endcase
        n_events++;
        if (ev_if.mode > rqs_pkg::EV_IDLE) n_ignored++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          rqs_pkg::CFG_PRIO_MODE: prio_on = cfg_if.data[0];
          rqs_pkg::CFG_SLICE:     slice_cfg = cfg_if.data;
          rqs_pkg::CFG_CPUS:      cpus_cfg = int'(cfg_if.data[4:0]);
          default: ;
        endcase
      end
    end
  end

  // receiver: stall style changes after each random span, one long hold-off
  initial begin : result_sink
    int  style;
    int  span;
    bit  held;
    res_if.ready = 1'b0;
    held = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(negedge clk);
        if (!held && n_events >= HOLD_AT) begin
          held = 1'b1;
          res_if.ready <= 1'b0;
          for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        end
        case (style)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= ($urandom_range(0, 1) == 1);
          2:       res_if.ready <= ($urandom_range(0, 3) != 0);
          default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d words still due", cycle_cnt, due_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // returns at the edge where the word was taken; valid stays up until the next send_event or release_events
  task automatic send_event(input logic [2:0] m, input logic [3:0] c,
                            input logic [7:0] p, input logic [7:0] pr);
    int gap;
    gap = 0;
    @(negedge clk);
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        6, 7, 8:          gap = $urandom_range(4, 12);
        default:          gap = 0;
      endcase
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (gap > 0) begin
        ev_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    ev_if.valid <= 1'b1;
    ev_if.mode <= m;
    ev_if.cpu <= c;
    ev_if.process_id <= p;
    ev_if.priority_req <= pr;
    do @(posedge clk); while (!ev_if.ready);
  endtask

  task automatic release_events();
    @(negedge clk);
    ev_if.valid <= 1'b0;
  endtask

  task automatic settle();
    while (due_results.size() != 0) @(posedge clk);
    // events with no word may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rqs_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic step_t ev(input logic [2:0] m, input logic [3:0] c,
                               input logic [7:0] p, input logic [7:0] pr,
                               input logic [4:0] n);
    step_t s;
    s = '0;
    s.row = ROW_EVENT;
    s.chk = CHK_PRED;
    s.mode = m;
    s.cpu = c;
    s.pid = p;
    s.prio = pr;
    s.reps = n;
    return s;
  endfunction

  function automatic step_t ev_none(input logic [2:0] m, input logic [3:0] c,
                                    input logic [7:0] p, input logic [7:0] pr);
    step_t s;
    s = ev(m, c, p, pr, 5'd1);
    s.chk = CHK_NONE;
    return s;
  endfunction

  function automatic step_t ev_res(input logic [2:0] m, input logic [3:0] c,
                                   input logic [7:0] p, input logic [7:0] pr,
                                   input rqs_pkg::result_t r);
    step_t s;
    s = ev(m, c, p, pr, 5'd1);
    s.chk = CHK_RES;
    s.res = r;
    return s;
  endfunction

  function automatic step_t cfg_row(input logic [rqs_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [15:0] val);
    step_t s;
    s = '0;
    s.row = ROW_CFG;
    s.chk = CHK_NONE;
    s.idx = idx;
    s.data = val;
    return s;
  endfunction

  function automatic rqs_pkg::result_t dispatch_res(input logic [3:0] c, input logic has,
                                                    input logic [7:0] p,
                                                    input logic [15:0] sl);
    return '{rqs_pkg::KIND_DISPATCH, c, has, p, sl, 1'b0};
  endfunction

  function automatic rqs_pkg::result_t kick_res(input logic [3:0] c, input logic ovf);
    return '{rqs_pkg::KIND_PREEMPT, c, 1'b0, 8'd0, 16'd0, ovf};
  endfunction

  initial begin : stimulus
    step_t       plan [PLAN_LEN];
    step_t       s;
    logic [2:0]  m;
    logic [3:0]  c;
    logic [7:0]  p;
    logic [7:0]  pr;
    int          sent;
    int          wake_pct;
    int          seg_left;
    int          roll;
    int          cpus_pick;

    rst_n = 1'b0;
    ev_if.valid = 1'b0;
    ev_if.mode = rqs_pkg::EV_WAKE;
    ev_if.cpu = '0;
    ev_if.process_id = '0;
    ev_if.priority_req = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = rqs_pkg::CFG_PRIO_MODE;
    cfg_if.data = '0;
    foreach (cpu_tab[i]) cpu_tab[i] = '0;
    prio_on = 1'b0;
    slice_cfg = '0;
    cpus_cfg = 1;
    row_check = CHK_PRED;
    row_res = '0;
    err_cnt = 0;
    n_events = 0;
    n_ignored = 0;
    n_results = 0;
    n_kicks = 0;
    n_idle_disp = 0;
    n_overflow = 0;
    burst_left = 0;

    plan = '{
      // fifo mode after reset, empty queue, all cpus idle
      ev_none(rqs_pkg::EV_IDLE, 4'd0, 8'd0, 8'd0),
      ev_res(EV_YIELD, 4'd15, 8'd0, 8'd0, dispatch_res(4'd15, 1'b0, 8'd0, 16'd0)),
      ev_res(EV_TERM, 4'd3, 8'd0, 8'd0, dispatch_res(4'd3, 1'b0, 8'd0, 16'd0)),
      ev_none(EV_LAST_UNUSED, 4'd0, 8'd0, 8'd0),
      ev_none(rqs_pkg::EV_WAKE, 4'd9, 8'd255, 8'd255),
      ev_none(rqs_pkg::EV_WAKE, 4'd0, 8'd0, 8'd0),
      ev_res(EV_YIELD, 4'd0, 8'd0, 8'd0, dispatch_res(4'd0, 1'b1, 8'd255, 16'd0)),
      // running process goes back first, the oldest entry comes out
      ev_res(rqs_pkg::EV_PREEMPT, 4'd0, 8'd0, 8'd0, dispatch_res(4'd0, 1'b1, 8'd0, 16'd0)),
      cfg_row(rqs_pkg::CFG_PRIO_MODE, 16'd1),
      cfg_row(rqs_pkg::CFG_SLICE, SLICE_MAX),
      cfg_row(rqs_pkg::CFG_CPUS, 16'd16),
      ev_res(rqs_pkg::EV_WAKE, 4'd0, 8'd1, 8'd128, kick_res(4'd0, 1'b0)),
      ev_res(rqs_pkg::EV_PREEMPT, 4'd0, 8'd0, 8'd0,
             dispatch_res(4'd0, 1'b1, 8'd255, SLICE_MAX)),
      ev_res(EV_YIELD, 4'd1, 8'd0, 8'd0, dispatch_res(4'd1, 1'b1, 8'd1, SLICE_MAX)),
      // fill the queue with equal-priority wakes, then overflow on a wake and a preempt
      ev(rqs_pkg::EV_WAKE, 4'd0, 8'd16, 8'd100, 5'd15),
      ev_res(rqs_pkg::EV_WAKE, 4'd7, 8'd77, 8'd255, kick_res(4'd1, 1'b1)),
      ev(rqs_pkg::EV_PREEMPT, 4'd0, 8'd0, 8'd0, 5'd1)
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      s = plan[i];
      if (s.row == ROW_CFG) begin
        release_events();
        settle();
        write_reg(s.idx, s.data);
      end else begin
        for (int k = 0; k < s.reps; k++) begin
          // takes effect after the checker has seen the word accepted at this edge
          row_check <= s.chk;
          row_res <= s.res;
          send_event(s.mode, s.cpu, s.pid + 8'(k), s.prio);
        end
      end
    end

    row_check <= CHK_PRED;
    for (int ph = 0; ph < PHASES; ph++) begin
      release_events();
      settle();
      write_reg(rqs_pkg::CFG_PRIO_MODE, 16'(ph % 2));
      if (ph == 0) write_reg(rqs_pkg::CFG_SLICE, 16'd0);
      else if (ph == 1) write_reg(rqs_pkg::CFG_SLICE, SLICE_MAX);
      else write_reg(rqs_pkg::CFG_SLICE, 16'($urandom_range(1, 65534)));
      if (ph == 1) cpus_pick = 1;
      else if (ph == 3) cpus_pick = N_CPUS;
      else cpus_pick = $urandom_range(2, N_CPUS - 1);
      write_reg(rqs_pkg::CFG_CPUS, 16'(cpus_pick));

      sent = 0;
      seg_left = 0;
      wake_pct = 40;
      while (sent < PHASE_ITEMS) begin
        // segments lean toward filling or draining the queue, or toward neither
        if (seg_left == 0) begin
          seg_left = $urandom_range(15, 40);
          case ($urandom_range(0, 2))
            0:       wake_pct = 40;
            1:       wake_pct = 80;
            default: wake_pct = 15;
          endcase
        end
        seg_left--;
        roll = $urandom_range(0, 99);
        if (roll >= 97) m = 3'($urandom_range(EV_FIRST_UNUSED, EV_LAST_UNUSED));
        else if (roll < wake_pct) m = rqs_pkg::EV_WAKE;
        else begin
          case ($urandom_range(0, 3))
            0:       m = rqs_pkg::EV_PREEMPT;
            1:       m = EV_YIELD;
            2:       m = EV_TERM;
            default: m = rqs_pkg::EV_IDLE;
          endcase
        end
        if ($urandom_range(0, 4) != 0) c = 4'($urandom_range(0, cpus_pick - 1));
        else c = 4'($urandom_range(0, N_CPUS - 1));
        p = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) < 2) pr = 8'($urandom_range(0, 3) * 85);
        else pr = 8'($urandom_range(0, 255));
        send_event(m, c, p, pr);
        if (m <= rqs_pkg::EV_IDLE) sent++;
      end
    end

    release_events();
    settle();
    $display("%0d events (%0d with unused codes) over %0d setups, %0d words checked",
             n_events, n_ignored, PHASES + 1, n_results);
    $display("%0d forced preemptions, %0d idle dispatches, %0d dropped inserts reported",
             n_kicks, n_idle_disp, n_overflow);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
